>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LRP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define LRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LRP_ASSERT(lbl, clk, rstn, prop)
`define LRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> design/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants of the log ring packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrp_pkg;

	localparam logic [1:0] REQ_APPEND_DRAIN = 2'd0;
	localparam logic [1:0] REQ_DRAIN        = 2'd1;
	localparam logic [1:0] REQ_APPEND       = 2'd2;

	localparam logic [7:0] HEAD_BYTE = 8'hAA;
	localparam logic [7:0] TAIL_BYTE = 8'hBB;

	localparam int unsigned    APB_ADDR_W       = 3;
	localparam logic [2:0]     ADDR_PACKET_TYPE = 3'd0;

	localparam int unsigned CNT_W    = 4;
	localparam int unsigned QUEUE_AW = 1;

	typedef struct packed {
		logic        append;
		logic        drain;
		logic [31:0] word;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_HEAD,
		S_TYPE,
		S_LEN,
		S_DATA,
		S_FETCH,
		S_TAIL
	} back_state_t;

endpackage

`default_nettype wire

>>> design/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front
// Accepts requests, decodes the request code into a command, registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module lrp_front import lrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] log_flag,
	input  wire logic [15:0] log_value,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_ready
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic keep;

	always_comb begin
		dec.word = {log_flag, log_value};
		unique case (req_type)
			REQ_APPEND_DRAIN: begin
				dec.append = 1'b1;
				dec.drain  = 1'b1;
			end
			REQ_DRAIN: begin
				dec.append = 1'b0;
				dec.drain  = 1'b1;
			end
			REQ_APPEND: begin
				dec.append = 1'b1;
				dec.drain  = 1'b0;
			end
			default: begin
				dec.append = 1'b0;
				dec.drain  = 1'b0;
			end
		endcase
		keep = dec.append | dec.drain;
	end

	assign req_ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= dec;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

>>> design/lrp_queue.sv
// ----------------------------------------------------------------------------
// lrp_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrp_queue import lrp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int unsigned DEPTH = 2 ** QUEUE_AW;

	cmd_t                  slot_q [DEPTH];
	logic [QUEUE_AW-1:0]   head_q;
	logic [QUEUE_AW-1:0]   tail_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != (QUEUE_AW + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= push_cmd;
		end
	end

	`LRP_ASSERT(a_count_bound, clk, arst_n, count_q <= (QUEUE_AW + 1)'(DEPTH))
	`LRP_ASSERT(a_ptr_gap, clk, arst_n,
		(count_q == (QUEUE_AW + 1)'(DEPTH)) || (head_q == tail_q) == (count_q == '0))

endmodule

`default_nettype wire

>>> design/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back
// Executes commands: appends to the ring memory, drains framed packets.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrp_back import lrp_pkg::*; #(
	parameter int unsigned LOG_DEPTH   = 256,
	parameter int unsigned MAX_ENTRIES = 15
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire cmd_t       cmd,
	input  wire logic [7:0] packet_type,
	output logic            pkt_valid,
	input  wire logic       pkt_ready,
	output logic [7:0]      out_byte,
	output logic            last_byte
);

	localparam int unsigned PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int unsigned DW = PW + 5;

	logic [31:0]      mem [LOG_DEPTH];
	logic [31:0]      rd_data_q;
	logic [PW-1:0]    rp_q;
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_next;
	logic [PW-1:0]    wp_next;
	logic [DW-1:0]    span;
	logic [CNT_W-1:0] n_calc;
	logic [CNT_W-1:0] left_q;
	logic [1:0]       bidx_q;
	back_state_t      state_q;
	back_state_t      state_d;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_free;
	logic             load;
	logic [7:0]       ld_byte;
	logic             ld_last;
	logic             take;

	assign out_free  = !out_valid_q || pkt_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;

	assign wp_next = (wp_q == PW'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == PW'(LOG_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	always_comb begin
		span = DW'(wp_q) - DW'(rp_q);
		if (wp_q < rp_q) begin
			span = span + DW'(LOG_DEPTH);
		end
		if (span > DW'(MAX_ENTRIES)) begin
			n_calc = CNT_W'(MAX_ENTRIES);
		end else begin
			n_calc = span[CNT_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && cmd.drain) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				state_d = (n_calc == '0) ? S_IDLE : S_HEAD;
			end
			S_HEAD: begin
				if (out_free) begin
					state_d = S_TYPE;
				end
			end
			S_TYPE: begin
				if (out_free) begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (out_free) begin
					state_d = S_DATA;
				end
			end
			S_DATA: begin
				if (out_free && bidx_q == 2'd3) begin
					state_d = (left_q == CNT_W'(1)) ? S_TAIL : S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_DATA;
			end
			S_TAIL: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		load    = 1'b0;
		ld_byte = HEAD_BYTE;
		ld_last = 1'b0;
		unique case (state_q)
			S_HEAD: begin
				load    = out_free;
				ld_byte = HEAD_BYTE;
			end
			S_TYPE: begin
				load    = out_free;
				ld_byte = packet_type;
			end
			S_LEN: begin
				load    = out_free;
				ld_byte = {2'b00, left_q, 2'b00};
			end
			S_DATA: begin
				load    = out_free;
				ld_byte = rd_data_q[8*bidx_q +: 8];
			end
			S_TAIL: begin
				load    = out_free;
				ld_byte = TAIL_BYTE;
				ld_last = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			left_q      <= '0;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && cmd.append && wp_next != rp_q) begin
				wp_q <= wp_next;
			end
			if (state_q == S_COUNT) begin
				left_q <= n_calc;
				bidx_q <= '0;
			end
			if (state_q == S_DATA && out_free) begin
				bidx_q <= bidx_q + 1'b1;
				if (bidx_q == 2'd3) begin
					left_q <= left_q - CNT_W'(1);
					rp_q   <= rp_next;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pkt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= ld_byte;
			out_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.append) begin
			mem[wp_q] <= cmd.word;
		end
		rd_data_q <= mem[rp_q];
	end

	assign pkt_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = out_last_q;

	`LRP_ASSERT(a_last_is_tail, clk, arst_n, !(out_valid_q && out_last_q) || out_byte_q == TAIL_BYTE)
	`LRP_ASSERT(a_data_left, clk, arst_n,
		!(state_q == S_DATA || state_q == S_FETCH) || left_q != '0)
	`LRP_ASSERT_NEXT(a_count_exit, clk, arst_n, state_q == S_COUNT,
		state_q == S_IDLE || state_q == S_HEAD)
	`LRP_ASSERT(a_wp_range, clk, arst_n,
		(wp_q <= PW'(LOG_DEPTH - 1)) && (rp_q <= PW'(LOG_DEPTH - 1)))

endmodule

`default_nettype wire

>>> design/log_ring_packetizer.sv
// A drain request passes the front register, the command queue and the back end's
// count and head states before the first packet byte is valid. A drain is paced by
// the one-read-port ring memory, with a refetch state between words. Requests are
// taken while a packet drains until the command queue and the front register
// hold three.
// Reset clears pointers, queue and control; ring memory contents are not cleared.
// ----------------------------------------------------------------------------
// log_ring_packetizer
// Log ring with framed packet drain: front decode, command queue, back executor.
// ----------------------------------------------------------------------------
`default_nettype none

module log_ring_packetizer import lrp_pkg::*; #(
	parameter int unsigned LOG_DEPTH   = 256,
	parameter int unsigned MAX_ENTRIES = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic [1:0]            req_type,
	input  wire logic [15:0]           log_flag,
	input  wire logic [15:0]           log_value,
	output logic                       pkt_valid,
	input  wire logic                  pkt_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_byte
);

	logic [7:0] packet_type_q;
	logic       fq_valid;
	logic       fq_ready;
	cmd_t       fq_cmd;
	logic       qb_valid;
	logic       qb_ready;
	cmd_t       qb_cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PACKET_TYPE) ? {24'd0, packet_type_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_type_q <= 8'd0;
		end else if (psel && penable && pwrite && paddr == ADDR_PACKET_TYPE) begin
			packet_type_q <= pwdata[7:0];
		end
	end

	lrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.log_flag  (log_flag),
		.log_value (log_value),
		.cmd_valid (fq_valid),
		.cmd       (fq_cmd),
		.cmd_ready (fq_ready)
	);

	lrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	lrp_back #(
		.LOG_DEPTH   (LOG_DEPTH),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (qb_valid),
		.cmd_ready   (qb_ready),
		.cmd         (qb_cmd),
		.packet_type (packet_type_q),
		.pkt_valid   (pkt_valid),
		.pkt_ready   (pkt_ready),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

endmodule

`default_nettype wire

>>> dv/log_ring_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_ring_packetizer_tb
// Drives log appends and drains into the packetizer, predicts the framed byte
// stream from a local copy of the log ring and packet type, and checks each
// packet byte against it. Random idling runs on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module log_ring_packetizer_tb;
	import lrp_pkg::*;

	localparam int          CLK_PERIOD  = 12;
	localparam int          RING_DEPTH  = 256;
	localparam int          DRAIN_MAX   = 15;
	localparam int          SETTLE      = 40;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam logic [1:0]  REQ_UNUSED  = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] flag;
		logic [15:0] value;
	} log_req_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} pkt_byte_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [31:0]           pwdata    = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	logic [1:0]            req_type  = '0;
	logic [15:0]           log_flag  = '0;
	logic [15:0]           log_value = '0;
	logic                  pkt_valid;
	logic                  pkt_ready = 1'b0;
	logic [7:0]            out_byte;
	logic                  last_byte;

	log_req_t  pending_reqs[$];
	pkt_byte_t expected_bytes[$];

	logic [31:0] ring_mem[RING_DEPTH];
	logic [7:0]  ring_rd;
	logic [7:0]  ring_wr;
	logic [7:0]  pkt_type_shadow;

	int idle_pct  = 0;
	int send_gap  = 0;
	int recv_gap  = 0;
	int err_count = 0;

	log_ring_packetizer #(
		.LOG_DEPTH  (RING_DEPTH),
		.MAX_ENTRIES(DRAIN_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type (req_type),
		.log_flag (log_flag),
		.log_value(log_value),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.out_byte (out_byte),
		.last_byte(last_byte)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic void push_byte(input logic [7:0] data, input logic last);
		pkt_byte_t b;
		b.data = data;
		b.last = last;
		expected_bytes.push_back(b);
	endfunction

	// Ring update and packet framing for one accepted request
	function automatic void predict_request(input log_req_t r);
		logic [7:0]  nxt;
		logic [31:0] words[DRAIN_MAX];
		int          n;
		if (r.kind == REQ_APPEND_DRAIN || r.kind == REQ_APPEND) begin
			ring_mem[ring_wr] = {r.flag, r.value};
			nxt = ring_wr + 8'd1;
			if (nxt != ring_rd)
				ring_wr = nxt;
		end
		if (r.kind == REQ_APPEND_DRAIN || r.kind == REQ_DRAIN) begin
			n = 0;
			while (ring_rd != ring_wr && n < DRAIN_MAX) begin
				words[n] = ring_mem[ring_rd];
				ring_rd  = ring_rd + 8'd1;
				n++;
			end
			if (n != 0) begin
				push_byte(HEAD_BYTE, 1'b0);
				push_byte(pkt_type_shadow, 1'b0);
				push_byte(8'(n * 4), 1'b0);
				for (int i = 0; i < n; i++)
					for (int b = 0; b < 4; b++)
						push_byte(words[i][8*b +: 8], 1'b0);
				push_byte(TAIL_BYTE, 1'b1);
			end
		end
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin : req_driver
		log_req_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap  <= 0;
		end else begin
			if (req_valid && req_ready) begin
				r.kind  = req_type;
				r.flag  = log_flag;
				r.value = log_value;
				predict_request(r);
			end
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					send_gap  <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					if ($urandom_range(0, 99) < idle_pct) begin
						send_gap  <= $urandom_range(0, 16);
						req_valid <= 1'b0;
					end else begin
						r = pending_reqs.pop_front();
						req_valid <= 1'b1;
						req_type  <= r.kind;
						log_flag  <= r.flag;
						log_value <= r.value;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Packet byte monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : pkt_monitor
		pkt_byte_t e;
		if (!arst_n) begin
			pkt_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (pkt_valid && pkt_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						out_byte, last_byte));
				end else begin
					e = expected_bytes.pop_front();
					if (out_byte !== e.data)
						report_mismatch($sformatf("out_byte %02h, want %02h",
							out_byte, e.data));
					if (last_byte !== e.last)
						report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
							last_byte, e.last, e.data));
				end
			end
			if (recv_gap != 0) begin
				recv_gap  <= recv_gap - 1;
				pkt_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				recv_gap  <= $urandom_range(0, 16);
				pkt_ready <= 1'b0;
			end else begin
				pkt_ready <= 1'b1;
			end
		end
	end

	task automatic add_req(input logic [1:0] kind, input logic [15:0] flag,
			input logic [15:0] value);
		log_req_t r;
		r.kind  = kind;
		r.flag  = flag;
		r.value = value;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [1:0] pick_kind();
		int w;
		w = $urandom_range(0, 99);
		if (w < 30)
			return REQ_APPEND_DRAIN;
		else if (w < 45)
			return REQ_DRAIN;
		else if (w < 95)
			return REQ_APPEND;
		else
			return REQ_UNUSED;
	endfunction

	task automatic add_random(input int count);
		repeat (count)
			add_req(pick_kind(), 16'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_packet_type(input logic [7:0] val);
		logic [31:0] rd;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_PACKET_TYPE;
		pwdata  <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pkt_type_shadow = val;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {24'd0, val})
			report_mismatch($sformatf("packet_type reads %08h, want %02h", rd, val));
	endtask

	initial begin : timeout
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		ring_rd         = '0;
		ring_wr         = '0;
		pkt_type_shadow = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty drain, unused code, extremes, drain cap
		set_packet_type(8'hFF);
		idle_pct = 15;
		add_req(REQ_DRAIN, 16'h1234, 16'h5678);
		add_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
		add_req(REQ_APPEND_DRAIN, 16'h0000, 16'h0000);
		add_req(REQ_APPEND_DRAIN, 16'hFFFF, 16'hFFFF);
		add_req(REQ_APPEND_DRAIN, 16'h5555, 16'hAAAA);
		for (int i = 0; i < 17; i++)
			add_req(REQ_APPEND, 16'(16'h8000 >> i), 16'(16'h0001 << i));
		add_req(REQ_DRAIN, 16'h0000, 16'h0000);
		add_req(REQ_DRAIN, 16'h0000, 16'h0000);
		add_req(REQ_DRAIN, 16'h0000, 16'h0000);
		wait_drained();

		set_packet_type(8'h00);
		idle_pct = 25;
		add_random(40);
		wait_drained();

		// build a backlog, then drain it out
		set_packet_type(8'($urandom));
		idle_pct = 10;
		repeat (30)
			add_req(REQ_APPEND, 16'($urandom), 16'($urandom));
		add_req(REQ_APPEND_DRAIN, 16'($urandom), 16'($urandom));
		repeat (3)
			add_req(REQ_DRAIN, 16'($urandom), 16'($urandom));
		add_random(10);
		wait_drained();

		set_packet_type(8'h80);
		idle_pct = 35;
		add_random(25);
		wait_drained();

		set_packet_type(8'($urandom));
		idle_pct = 0;
		add_random(20);
		wait_drained();

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
